// ===== hw/rtl/sbt_pkg.sv =====
// shared types, constants and byte classification for the source byte tokenizer
`default_nettype none

package sbt_pkg;

    localparam int POS_W_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [7:0] UTF_HI_BIT  = 8'h80;
    localparam logic [7:0] UTF_MASK2   = 8'hE0;
    localparam logic [7:0] UTF_LEAD2   = 8'hC0;
    localparam logic [7:0] UTF_MASK3   = 8'hF0;
    localparam logic [7:0] UTF_LEAD3   = 8'hE0;
    localparam logic [7:0] UTF_MASK4   = 8'hF8;
    localparam logic [7:0] UTF_LEAD4   = 8'hF0;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_GLYPH  = 3'd2,
        KIND_PUNCT  = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_SKIP,
        MODE_DROP
    } mode_t;

    typedef struct packed {
        logic        last_of_text;
        logic [15:0] token_total;
        logic        overflow;
        logic [15:0] line_number;
        logic [15:0] token_length;
        logic [15:0] start_offset;
        logic [2:0]  token_kind;
    } tok_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] n;
        if ((c & UTF_HI_BIT) == 8'h00)
            n = 3'd1;
        else if ((c & UTF_MASK2) == UTF_LEAD2)
            n = 3'd2;
        else if ((c & UTF_MASK3) == UTF_LEAD3)
            n = 3'd3;
        else if ((c & UTF_MASK4) == UTF_LEAD4)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/source_byte_tokenizer.sv =====
// source byte tokenizer: top level with scanner state and result queue
//
// usage: one source byte per item on the s_* channel, byte zero ends a text.
// tokens come out on the m_* channel: tdata carries kind, start offset, length,
// line and running token count, tuser flags an overflow item, tlast marks the
// last item of a text (end token or overflow).
// token_capacity is written over the apb port at address 0; the user must write
// it only while the block idles, which the block itself does not enforce.
// throughput: one byte per cycle; a byte that closes a pending token and is a
// token itself gives two items, drained one per cycle through a four-entry queue.
// s_tready is high whenever the queue has room for two items, so a stalled
// receiver holds off the sender after the queue fills; nothing is lost.
// reset clears the scanner to the start of a text, empties the queue and sets
// token_capacity to 65535; after an end byte the scanner restarts on its own.
`default_nettype none

module source_byte_tokenizer #(
    parameter int POS_W       = sbt_pkg::POS_W_DEFAULT,
    parameter int QUEUE_DEPTH = sbt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,     // byte_value
    output logic        m_tvalid,
    input  wire         m_tready,
    // token_kind[2:0], start_offset[18:3], token_length[34:19],
    // line_number[50:35], token_total[66:51], zero pad[71:67]
    output logic [71:0] m_tdata,
    output logic [0:0]  m_tuser,     // overflow
    output logic        m_tlast,     // last_of_text
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbt_pkg::*;

    logic [15:0]      cap_reg;
    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] ps_reg, ps_next;
    logic [POS_W-1:0] pl_reg, pl_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic [1:0]       skip_reg, skip_next;

    logic             accept;
    logic             room2;
    logic [7:0]       c;
    logic             fall;
    logic             restart;
    logic             e1_valid, e2_valid;
    logic             ok1, ok2;
    logic [15:0]      cnt1, cnt2;
    tok_t             e1, e2, push0, push1;
    logic [1:0]       push_cnt;
    logic [2:0]       glen;
    logic [POS_W-1:0] pos_inc;
    tok_t             q_item;

    function automatic logic [POS_W-1:0] inc_sat(input logic [POS_W-1:0] v);
        return (v == '1) ? v : v + POS_W'(1);
    endfunction

    function automatic logic [15:0] clamp16(input logic [POS_W-1:0] v);
        return (POS_W > 16 && (v >> 16) != '0) ? 16'hFFFF : 16'(v);
    endfunction

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'h0000, cap_reg} : 32'h0;
    assign s_tready = room2;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign pos_inc  = inc_sat(pos_reg);
    assign glen     = lead_len(c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 16'hFFFF;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            cap_reg <= pwdata[15:0];
    end

    always_comb
    begin
        mode_next = mode_reg;
        ps_next   = ps_reg;
        pl_next   = pl_reg;
        pos_next  = pos_reg;
        line_next = line_reg;
        skip_next = skip_reg;
        fall      = 1'b0;
        restart   = 1'b0;
        e1_valid  = 1'b0;
        e2_valid  = 1'b0;
        ok1       = (cnt_reg < cap_reg);
        e1        = '0;
        e2        = '0;
        e1.line_number = clamp16(line_reg);
        e2.line_number = clamp16(line_reg);
        e2.start_offset = clamp16(pos_reg);

        if (accept)
        begin
            case (mode_reg)
                MODE_DROP:
                begin
                    if (c == CH_NUL)
                        restart = 1'b1;
                    else
                        pos_next = pos_inc;
                end
                MODE_SKIP:
                begin
                    if (c != CH_NUL)
                    begin
                        skip_next = skip_reg - 2'd1;
                        if (skip_reg == 2'd1)
                            mode_next = MODE_IDLE;
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        skip_next = 2'd0;
                        mode_next = MODE_IDLE;
                        fall      = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c != CH_NUL && c != CH_LF)
                        pos_next = pos_inc;
                    else
                    begin
                        mode_next = MODE_IDLE;
                        fall      = 1'b1;
                    end
                end
                MODE_IDENT, MODE_NUMBER, MODE_SLASH:
                begin
                    if (mode_reg == MODE_SLASH && c == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        pos_next  = pos_inc;
                    end
                    else if ((mode_reg == MODE_IDENT && (is_letter(c) || is_numeral(c)))
                             || (mode_reg == MODE_NUMBER && is_numeral(c)))
                    begin
                        pl_next  = inc_sat(pl_reg);
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        e1_valid        = 1'b1;
                        e1.start_offset = clamp16(ps_reg);
                        case (mode_reg)
                            MODE_IDENT:
                            begin
                                e1.token_kind   = KIND_IDENT;
                                e1.token_length = clamp16(pl_reg);
                            end
                            MODE_NUMBER:
                            begin
                                e1.token_kind   = KIND_NUMBER;
                                e1.token_length = clamp16(pl_reg);
                            end
                            default:
                            begin
                                e1.token_kind   = KIND_PUNCT;
                                e1.token_length = 16'd1;
                            end
                        endcase
                        if (!ok1)
                        begin
                            mode_next = MODE_DROP;
                            if (c == CH_NUL)
                                restart = 1'b1;
                            else
                                pos_next = pos_inc;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                            fall      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    fall      = 1'b1;
                end
            endcase
        end

        cnt1 = (e1_valid && ok1) ? cnt_reg + 16'd1 : cnt_reg;
        ok2  = (cnt1 < cap_reg);
        e1.overflow     = !ok1;
        e1.token_total  = cnt1;
        e1.last_of_text = !ok1;

        if (fall)
        begin
            pos_next = pos_inc;
            if (c == CH_NUL)
            begin
                e2_valid        = 1'b1;
                e2.token_kind   = KIND_END;
                e2.token_length = 16'd0;
                restart         = 1'b1;
            end
            else if (c == CH_LF)
                line_next = inc_sat(line_reg);
            else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
                pos_next = pos_inc;
            else if (c == CH_SLASH || is_letter(c) || is_numeral(c))
            begin
                mode_next = (c == CH_SLASH) ? MODE_SLASH
                          : (is_letter(c) ? MODE_IDENT : MODE_NUMBER);
                ps_next   = pos_reg;
                pl_next   = POS_W'(1);
            end
            else
            begin
                e2_valid        = 1'b1;
                e2.token_kind   = c[7] ? KIND_GLYPH : KIND_PUNCT;
                e2.token_length = 16'(glen);
                if (!ok2)
                    mode_next = MODE_DROP;
                else if (glen > 3'd1)
                begin
                    mode_next = MODE_SKIP;
                    skip_next = 2'(glen - 3'd1);
                end
            end
        end

        cnt2 = (e2_valid && ok2) ? cnt1 + 16'd1 : cnt1;
        e2.overflow     = !ok2;
        e2.token_total  = cnt2;
        e2.last_of_text = (e2.token_kind == KIND_END) || !ok2;
        cnt_next = cnt2;

        if (restart)
        begin
            mode_next = MODE_IDLE;
            ps_next   = '0;
            pl_next   = '0;
            pos_next  = '0;
            line_next = POS_W'(1);
            cnt_next  = 16'd0;
            skip_next = 2'd0;
        end

        if (e1_valid)
        begin
            push0    = e1;
            push1    = e2;
            push_cnt = e2_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            push0    = e2;
            push1    = e2;
            push_cnt = e2_valid ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            ps_reg   <= '0;
            pl_reg   <= '0;
            pos_reg  <= '0;
            line_reg <= POS_W'(1);
            cnt_reg  <= 16'd0;
            skip_reg <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            ps_reg   <= ps_next;
            pl_reg   <= pl_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
        end
    end

    sbt_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (q_item)
    );

    assign m_tdata = {5'b00000, q_item.token_total, q_item.line_number,
                      q_item.token_length, q_item.start_offset, q_item.token_kind};
    assign m_tuser = q_item.overflow;
    assign m_tlast = q_item.last_of_text;

endmodule

`default_nettype wire

// ===== hw/rtl/sbt_out_queue.sv =====
// small result queue taking up to two items per cycle, giving one per cycle while out_ready is high
`default_nettype none

module sbt_out_queue #(
    parameter int DEPTH = sbt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire [1:0]         push_cnt,
    input  sbt_pkg::tok_t     push0,
    input  sbt_pkg::tok_t     push1,
    output logic              room2,
    output logic              out_valid,
    input  wire               out_ready,
    output sbt_pkg::tok_t     out_item
);
    import sbt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_p1;

    // pointer advance with wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(n);
        if (s >= (PTR_W+1)'(DEPTH))
            s = s - (PTR_W+1)'(DEPTH);
        return s[PTR_W-1:0];
    endfunction

    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign room2     = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = ptr_add(wr_ptr_reg, 2'd1);

    always_comb
    begin
        wr_ptr_next = ptr_add(wr_ptr_reg, push_cnt);
        rd_ptr_next = pop ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            slot_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            slot_reg[wr_ptr_p1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbt_checker.sv =====
// port-level checks for the source byte tokenizer and their binding
`default_nettype none

module sbt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [71:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        m_tlast
);
    import sbt_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // overflow item closes the text
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("overflow item without last");

    // end token closes the text and has no length
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == KIND_END |-> m_tlast && m_tdata[34:19] == 16'd0)
        else $error("bad end token");

    // normal token counts itself and lines start at one
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[66:51] != 16'd0 && m_tdata[50:35] != 16'd0)
        else $error("token total or line is zero");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/tb_source_byte_tokenizer.sv =====
`timescale 1ns / 100ps
// testbench for the source byte tokenizer: byte texts driven in, tokens checked against a predictor
module tb_source_byte_tokenizer;

    import sbt_pkg::*;

    localparam logic [2:0] ADDR_TOKEN_CAPACITY = 3'd0;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 117;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire  [0:0]  m_tuser;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;

    class token_tracker;
        logic [15:0] capacity;
        mode_t       mode;
        logic [15:0] tok_start;
        logic [15:0] tok_len;
        logic [15:0] offset;
        logic [15:0] cur_line;
        logic [15:0] emitted;
        logic [1:0]  skip_left;
        tok_t        pending_tokens[$];
        int          errors;

        function new();
            capacity = 16'hFFFF;
            errors = 0;
            restart();
        endfunction

        function void restart();
            mode = MODE_IDLE;
            tok_start = 16'd0;
            tok_len = 16'd0;
            offset = 16'd0;
            cur_line = 16'd1;
            emitted = 16'd0;
            skip_left = 2'd0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function int glyph_len(logic [7:0] c);
            if ((c & UTF_MASK2) == UTF_LEAD2)
                return 2;
            if ((c & UTF_MASK3) == UTF_LEAD3)
                return 3;
            if ((c & UTF_MASK4) == UTF_LEAD4)
                return 4;
            return 1;
        endfunction

        // queues a token, or the overflow item once capacity is used up
        function bit push_token(kind_t kind, logic [15:0] start, logic [15:0] len, bit last);
            tok_t t;
            bit   ok;
            ok = emitted < capacity;
            if (ok)
                emitted = emitted + 16'd1;
            t.token_kind = kind;
            t.start_offset = start;
            t.token_length = len;
            t.line_number = cur_line;
            t.overflow = !ok;
            t.token_total = emitted;
            t.last_of_text = last || !ok;
            pending_tokens.push_back(t);
            if (!ok)
                mode = MODE_DROP;
            return ok;
        endfunction

        function void take_byte(logic [7:0] c);
            logic [15:0] p;
            bit          word;
            bit          more;
            int          glen;
            p = offset;
            case (mode)
                MODE_DROP:
                begin
                    if (c == CH_NUL)
                        restart();
                    else
                        offset = bump(p);
                    return;
                end
                MODE_SKIP:
                begin
                    if (c != CH_NUL)
                    begin
                        skip_left = skip_left - 2'd1;
                        if (skip_left == 2'd0)
                            mode = MODE_IDLE;
                        offset = bump(p);
                        return;
                    end
                    skip_left = 2'd0;
                    mode = MODE_IDLE;
                end
                MODE_COMMENT:
                begin
                    if (c != CH_NUL && c != CH_LF)
                    begin
                        offset = bump(p);
                        return;
                    end
                    mode = MODE_IDLE;
                end
                MODE_IDENT, MODE_NUMBER:
                begin
                    word = (mode == MODE_IDENT);
                    more = word ? (is_alpha(c) || is_num(c)) : is_num(c);
                    if (more)
                    begin
                        tok_len = bump(tok_len);
                        offset = bump(p);
                        return;
                    end
                    mode = MODE_IDLE;
                    if (!push_token(word ? KIND_IDENT : KIND_NUMBER, tok_start, tok_len, 1'b0))
                    begin
                        if (c == CH_NUL)
                            restart();
                        else
                            offset = bump(p);
                        return;
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode = MODE_COMMENT;
                        offset = bump(p);
                        return;
                    end
                    mode = MODE_IDLE;
                    if (!push_token(KIND_PUNCT, tok_start, 16'd1, 1'b0))
                    begin
                        if (c == CH_NUL)
                            restart();
                        else
                            offset = bump(p);
                        return;
                    end
                end
                default:
                    mode = MODE_IDLE;
            endcase

            if (c == CH_NUL)
            begin
                void'(push_token(KIND_END, p, 16'd0, 1'b1));
                restart();
                return;
            end
            if (c == CH_LF)
                cur_line = bump(cur_line);
            else if (c == CH_SLASH)
            begin
                mode = MODE_SLASH;
                tok_start = p;
                tok_len = 16'd1;
            end
            else if (is_alpha(c))
            begin
                mode = MODE_IDENT;
                tok_start = p;
                tok_len = 16'd1;
            end
            else if (is_num(c))
            begin
                mode = MODE_NUMBER;
                tok_start = p;
                tok_len = 16'd1;
            end
            else if (c[7])
            begin
                glen = glyph_len(c);
                if (push_token(KIND_GLYPH, p, 16'(glen), 1'b0) && glen > 1)
                begin
                    mode = MODE_SKIP;
                    skip_left = 2'(glen - 1);
                end
            end
            else if (c != CH_SPACE && c != CH_TAB && c != CH_CR)
                void'(push_token(KIND_PUNCT, p, 16'd1, 1'b0));
            offset = bump(p);
        endfunction

        task flag(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task cmp(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                flag($sformatf("%s got %0h expected %0h", field, got, want));
        endtask

        task match_token(logic [71:0] d, logic ovf, logic last);
            tok_t t;
            if (pending_tokens.size() == 0)
            begin
                flag($sformatf("unexpected item %h", d));
                return;
            end
            t = pending_tokens.pop_front();
            cmp("token_kind", {13'd0, d[2:0]}, {13'd0, t.token_kind});
            cmp("start_offset", d[18:3], t.start_offset);
            cmp("token_length", d[34:19], t.token_length);
            cmp("line_number", d[50:35], t.line_number);
            cmp("token_total", d[66:51], t.token_total);
            cmp("pad", {11'd0, d[71:67]}, 16'd0);
            cmp("overflow", {15'd0, ovf}, {15'd0, t.overflow});
            cmp("last_of_text", {15'd0, last}, {15'd0, t.last_of_text});
        endtask
    endclass

    token_tracker tracker = new();
    int           send_idle;
    int           recv_idle;
    int           cycles;
    logic [7:0]   text_q[$];

    source_byte_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_source_byte_tokenizer: FAIL");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.match_token(m_tdata, m_tuser[0], m_tlast);
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function logic [7:0] rand_alpha();
        int v;
        v = $urandom_range(0, 52);
        if (v < 26)
            return 8'h41 + 8'(v);
        if (v < 52)
            return 8'h61 + 8'(v - 26);
        return CH_UNDER;
    endfunction

    function logic [7:0] utf_lead(int n);
        case (n)
            2:       return UTF_LEAD2 | 8'($urandom_range(0, 31));
            3:       return UTF_LEAD3 | 8'($urandom_range(0, 15));
            default: return UTF_LEAD4 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    // continuation bytes are skipped unexamined, so any nonzero byte may stand there
    function logic [7:0] utf_cont();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        return UTF_HI_BIT | 8'($urandom_range(0, 63));
    endfunction

    task build_text();
        int         pieces;
        int         pick;
        int         n;
        logic [7:0] b;
        text_q.delete();
        pieces = $urandom_range(0, 12);
        for (int i = 0; i < pieces; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                text_q.push_back(rand_alpha());
                n = $urandom_range(0, 8);
                repeat (n)
                    text_q.push_back($urandom_range(0, 3) == 0 ?
                                     8'h30 + 8'($urandom_range(0, 9)) : rand_alpha());
            end
            else if (pick < 40)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            else if (pick < 50)
            begin
                case ($urandom_range(0, 2))
                    0:       text_q.push_back(CH_SPACE);
                    1:       text_q.push_back(CH_TAB);
                    default: text_q.push_back(CH_CR);
                endcase
            end
            else if (pick < 57)
                text_q.push_back(CH_LF);
            else if (pick < 64)
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_LF)
                        b = 8'h0B;
                    text_q.push_back(b);
                end
                if ($urandom_range(0, 4) != 0)
                    text_q.push_back(CH_LF);
            end
            else if (pick < 69)
                text_q.push_back(CH_SLASH);
            else if (pick < 79)
                text_q.push_back(8'($urandom_range(1, 127)));
            else if (pick < 89)
            begin
                n = $urandom_range(2, 4);
                text_q.push_back(utf_lead(n));
                repeat (n - 1)
                    text_q.push_back(utf_cont());
            end
            else if (pick < 93)
                text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF)) :
                                                        8'($urandom_range(8'hF8, 8'hFF)));
            else
                text_q.push_back(8'($urandom_range(1, 255)));
        end
        // glyph cut short by the end byte
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(2, 4);
            text_q.push_back(utf_lead(n));
            if (n > 2 && $urandom_range(0, 1) == 1)
                text_q.push_back(utf_cont());
        end
        text_q.push_back(CH_NUL);
    endtask

    task send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        tracker.take_byte(b);
        @(negedge clk);
    endtask

    task send_text();
        foreach (text_q[i])
            send_byte(text_q[i]);
    endtask

    task write_capacity(input logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TOKEN_CAPACITY;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.capacity = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task check_capacity();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_TOKEN_CAPACITY;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'd0, tracker.capacity})
            tracker.flag($sformatf("token_capacity read %h expected %h", prdata,
                                   tracker.capacity));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for every queued token, then let a dropped end byte work through
    task settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] cap;
        int          sent;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_capacity();

        text_q = '{8'h41, 8'h7A, 8'h5F, 8'h39, 8'h20, 8'h30, 8'h39, 8'h2B,
                   8'h2F, 8'h2F, 8'h71, 8'h0A, 8'h2F, 8'h61, 8'h09, 8'h0D,
                   8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'h80, 8'h00,
                   8'h37, 8'hE2, 8'h00, 8'h2F, 8'h00};
        send_text();
        settle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph / 4)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 81;
                end
                1:
                begin
                    send_idle = 81;
                    recv_idle = 30;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (ph)
                0:       cap = 16'd0;
                1:       cap = 16'd1;
                2:       cap = 16'd3;
                3:       cap = 16'hFFFF;
                4:       cap = 16'd2;
                5:       cap = 16'($urandom_range(4, 8));
                6:       cap = 16'($urandom);
                7:       cap = 16'd1;
                8:       cap = 16'($urandom_range(1, 6));
                9:       cap = 16'd0;
                10:      cap = 16'($urandom);
                default: cap = 16'hFFFF;
            endcase
            write_capacity(cap);
            check_capacity();
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_text();
                sent += text_q.size();
                send_text();
            end
            settle();
        end

        if (tracker.errors == 0)
            $display("tb_source_byte_tokenizer: PASS");
        else
            $display("tb_source_byte_tokenizer: FAIL");
        $finish;
    end

endmodule
